### sv/pdds_pkg.sv
// pdds_pkg: constants, command and result codes of the display dimming scheduler
// no dependencies
`default_nettype none

package pdds_pkg;

	// brightness scale
	localparam int MAX_BRIGHTNESS = 8;
	localparam int MIN_BRIGHTNESS = 1;
	localparam int PREHEAT_STEPS  = 1;

	// port field widths
	localparam int COMMAND_W   = 3;
	localparam int LEVEL_REQ_W = 8;
	localparam int WORD_W      = 64;
	localparam int LEVEL_NOW_W = 4;

	// internal widths
	localparam int LEVEL_W = $clog2(MAX_BRIGHTNESS + 1);
	localparam int PHASE_W = $clog2(MAX_BRIGHTNESS);
	localparam int CMP_W   = 8;

	localparam logic [WORD_W-1:0] ALL_ONES   = '1;
	localparam logic [WORD_W-1:0] ALL_ZEROS  = '0;

	localparam logic [CMP_W-1:0] MAX_C     = CMP_W'(MAX_BRIGHTNESS);
	localparam logic [CMP_W-1:0] MIN_C     = CMP_W'(MIN_BRIGHTNESS);
	localparam logic [CMP_W-1:0] PREHEAT_C = CMP_W'(PREHEAT_STEPS);
	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(MAX_BRIGHTNESS - 1);

	typedef enum logic [COMMAND_W-1:0] {
		CMD_TICK      = 3'd0,
		CMD_SET       = 3'd1,
		CMD_UP        = 3'd2,
		CMD_UP_WRAP   = 3'd3,
		CMD_DOWN      = 3'd4,
		CMD_DOWN_WRAP = 3'd5,
		CMD_OFF       = 3'd6,
		CMD_LOAD      = 3'd7
	} command_t;

	typedef enum logic {
		KIND_SHIFT = 1'b0,
		KIND_LEVEL = 1'b1
	} kind_t;

	// clamp a requested level to MIN..MAX
	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [CMP_W-1:0] req);
		logic [CMP_W-1:0] r;
		begin
			if (req < MIN_C)
				r = MIN_C;
			else if (req > MAX_C)
				r = MAX_C;
			else
				r = req;
			return LEVEL_W'(r);
		end
	endfunction

endpackage

`default_nettype wire

### sv/pdds_cmd_if.sv
// pdds_cmd_if: valid/ready command channel of the display dimming scheduler
// depends on pdds_pkg for field widths
`default_nettype none

interface pdds_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [pdds_pkg::COMMAND_W-1:0]     command;
	logic [pdds_pkg::LEVEL_REQ_W-1:0]   level_request;
	logic [pdds_pkg::WORD_W-1:0]        segment_word;

	modport source (output valid, command, level_request, segment_word, input ready);
	modport sink   (input valid, command, level_request, segment_word, output ready);
endinterface

`default_nettype wire

### sv/pdds_res_if.sv
// pdds_res_if: valid/ready result channel of the display dimming scheduler
// depends on pdds_pkg for field widths
`default_nettype none

interface pdds_res_if;
	logic                               valid;
	logic                               ready;
	logic                               result_kind;
	logic [pdds_pkg::WORD_W-1:0]        shift_word;
	logic [pdds_pkg::LEVEL_NOW_W-1:0]   level_now;
	logic                               last;

	modport source (output valid, result_kind, shift_word, level_now, last, input ready);
	modport sink   (input valid, result_kind, shift_word, level_now, last, output ready);
endinterface

`default_nettype wire

### sv/pwm_display_dimming_scheduler.sv
// pwm_display_dimming_scheduler: brightness level, pwm phase and segment pattern
// depends on pdds_pkg, pdds_cmd_if, pdds_res_if
`default_nettype none

// Each command beat is decoded in the cycle it is accepted: level, phase and pattern
// update at once and the results it causes go into one staging register, which
// feeds the output register. Commands that change the level give one brightness
// report; a tick gives zero, one or two shift words (the preheat step gives an
// all-zeros word and then the pattern, the second with last set); a load gives
// nothing. A command with one result or none frees the staging register as that
// result moves on; a preheat tick holds it until both words have left through the
// one output register. That register lets a new command in while a result waits.

module pwm_display_dimming_scheduler (
	input  wire          clk,
	input  wire          arst_n,
	pdds_cmd_if.sink     cmd,
	pdds_res_if.source   res
);

	localparam int LW = pdds_pkg::LEVEL_W;
	localparam int PW = pdds_pkg::PHASE_W;
	localparam int CW = pdds_pkg::CMP_W;
	localparam int WW = pdds_pkg::WORD_W;

	// architectural state
	logic [LW-1:0] level_q;
	logic [PW-1:0] phase_q;
	logic [WW-1:0] pattern_q;

	// staging register
	logic                  valid_s1;
	logic                  two_s1;
	pdds_pkg::kind_t       kind_s1;
	logic [WW-1:0]         word0_s1;
	logic [WW-1:0]         word1_s1;
	logic [LW-1:0]         level_s1;

	// output register
	logic                  valid_q;
	pdds_pkg::kind_t       kind_q;
	logic [WW-1:0]         word_q;
	logic [LW-1:0]         lvl_q;
	logic                  last_q;

	pdds_pkg::command_t    command;
	logic [CW-1:0]         level_x;
	logic [CW-1:0]         phase_x;
	logic                  accept;
	logic                  out_load;
	logic                  s1_drain;

	logic [LW-1:0]         level_d;
	logic                  emit;
	logic                  two_d;
	pdds_pkg::kind_t       kind_d;
	logic [WW-1:0]         word0_d;

	assign command = pdds_pkg::command_t'(cmd.command);
	assign level_x = CW'(level_q);
	assign phase_x = CW'(phase_q);

	assign out_load = valid_s1 && (!valid_q || res.ready);
	assign s1_drain = out_load && !two_s1;
	assign cmd.ready = !valid_s1 || s1_drain;
	assign accept = cmd.valid && cmd.ready;

	// command decode
	always_comb begin
		level_d = level_q;
		emit    = 1'b1;
		two_d   = 1'b0;
		kind_d  = pdds_pkg::KIND_LEVEL;
		word0_d = pdds_pkg::ALL_ZEROS;
		unique case (command)
			pdds_pkg::CMD_TICK: begin
				kind_d = pdds_pkg::KIND_SHIFT;
				if (phase_x == level_x) begin
					word0_d = pdds_pkg::ALL_ZEROS;
				end else if (level_x >= pdds_pkg::PREHEAT_C &&
						phase_x == pdds_pkg::PREHEAT_C) begin
					word0_d = pdds_pkg::ALL_ZEROS;
					two_d   = 1'b1;
				end else if (phase_q == '0) begin
					word0_d = pdds_pkg::ALL_ONES;
				end else begin
					emit = 1'b0;
				end
			end
			pdds_pkg::CMD_SET: begin
				level_d = pdds_pkg::clamp_level(CW'(cmd.level_request));
			end
			pdds_pkg::CMD_UP: begin
				if (level_x < pdds_pkg::MAX_C)
					level_d = level_q + LW'(1);
			end
			pdds_pkg::CMD_UP_WRAP: begin
				if (level_x >= pdds_pkg::MAX_C)
					level_d = pdds_pkg::clamp_level(pdds_pkg::MIN_C);
				else
					level_d = level_q + LW'(1);
			end
			pdds_pkg::CMD_DOWN: begin
				if (level_x > pdds_pkg::MIN_C)
					level_d = level_q - LW'(1);
			end
			pdds_pkg::CMD_DOWN_WRAP: begin
				if (level_x <= pdds_pkg::MIN_C)
					level_d = pdds_pkg::clamp_level(pdds_pkg::MAX_C);
				else
					level_d = level_q - LW'(1);
			end
			pdds_pkg::CMD_OFF: begin
				level_d = '0;
			end
			pdds_pkg::CMD_LOAD: begin
				emit = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= LW'(pdds_pkg::MAX_BRIGHTNESS);
			phase_q   <= '0;
			pattern_q <= '0;
		end else if (accept) begin
			level_q <= level_d;
			if (command == pdds_pkg::CMD_TICK)
				phase_q <= (phase_q == pdds_pkg::PHASE_LAST) ? '0 : phase_q + PW'(1);
			if (command == pdds_pkg::CMD_LOAD)
				pattern_q <= cmd.segment_word;
		end
	end

	// staging register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			two_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
			two_s1   <= two_d;
		end else if (out_load) begin
			// second word of a preheat tick moves to the head
			valid_s1 <= two_s1;
			two_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_d;
			word0_s1 <= word0_d;
			word1_s1 <= pattern_q;
			level_s1 <= level_d;
		end else if (out_load && two_s1) begin
			word0_s1 <= word1_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (out_load)
			valid_q <= 1'b1;
		else if (res.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= kind_s1;
			word_q <= word0_s1;
			lvl_q  <= (kind_s1 == pdds_pkg::KIND_LEVEL) ? level_s1 : '0;
			last_q <= !two_s1;
		end
	end

	assign res.valid       = valid_q;
	assign res.result_kind = kind_q;
	assign res.shift_word  = word_q;
	assign res.level_now   = pdds_pkg::LEVEL_NOW_W'(lvl_q);
	assign res.last        = last_q;

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for pwm_display_dimming_scheduler
// depends on pdds_pkg, pdds_cmd_if, pdds_res_if and the scheduler itself

module tb_top;

	typedef struct {
		logic                             kind;
		logic [pdds_pkg::WORD_W-1:0]      word;
		logic [pdds_pkg::LEVEL_NOW_W-1:0] lvl;
		logic                             last;
	} display_beat_t;

	logic clk;
	logic arst_n;

	pdds_cmd_if cmd_bus ();
	pdds_res_if res_bus ();

	pwm_display_dimming_scheduler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus)
	);

	// predicted scheduler state
	int                          dim_level;
	int                          pwm_phase;
	logic [pdds_pkg::WORD_W-1:0] seg_pattern;

	display_beat_t expected_beats[$];
	int            mismatch_count;
	bit            allow_gaps;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int draw_wait();
		if (!allow_gaps)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	function automatic int clamp_request(int req);
		if (req < pdds_pkg::MIN_BRIGHTNESS)
			return pdds_pkg::MIN_BRIGHTNESS;
		if (req > pdds_pkg::MAX_BRIGHTNESS)
			return pdds_pkg::MAX_BRIGHTNESS;
		return req;
	endfunction

	function automatic void push_beat(logic kind, logic [pdds_pkg::WORD_W-1:0] word, int lvl,
			logic last);
		display_beat_t b;
		b.kind = kind;
		b.word = word;
		b.lvl  = pdds_pkg::LEVEL_NOW_W'(lvl);
		b.last = last;
		expected_beats.push_back(b);
	endfunction

	// advance the predicted state by one command and queue the beats it causes
	function automatic void predict_display(pdds_pkg::command_t c,
			logic [pdds_pkg::LEVEL_REQ_W-1:0] req, logic [pdds_pkg::WORD_W-1:0] w);
		case (c)
			pdds_pkg::CMD_TICK: begin
				if (pwm_phase == dim_level) begin
					push_beat(pdds_pkg::KIND_SHIFT, pdds_pkg::ALL_ZEROS, 0, 1'b1);
				end else if (dim_level >= pdds_pkg::PREHEAT_STEPS &&
						pwm_phase == pdds_pkg::PREHEAT_STEPS) begin
					push_beat(pdds_pkg::KIND_SHIFT, pdds_pkg::ALL_ZEROS, 0, 1'b0);
					push_beat(pdds_pkg::KIND_SHIFT, seg_pattern, 0, 1'b1);
				end else if (pwm_phase == 0) begin
					push_beat(pdds_pkg::KIND_SHIFT, pdds_pkg::ALL_ONES, 0, 1'b1);
				end
				pwm_phase = (pwm_phase + 1 >= pdds_pkg::MAX_BRIGHTNESS) ? 0 : pwm_phase + 1;
			end
			pdds_pkg::CMD_LOAD: seg_pattern = w;
			default: begin
				case (c)
					pdds_pkg::CMD_SET: dim_level = clamp_request(int'(req));
					pdds_pkg::CMD_UP: begin
						if (dim_level < pdds_pkg::MAX_BRIGHTNESS)
							dim_level++;
					end
					pdds_pkg::CMD_UP_WRAP: begin
						if (dim_level >= pdds_pkg::MAX_BRIGHTNESS)
							dim_level = clamp_request(pdds_pkg::MIN_BRIGHTNESS);
						else
							dim_level++;
					end
					pdds_pkg::CMD_DOWN: begin
						if (dim_level > pdds_pkg::MIN_BRIGHTNESS)
							dim_level--;
					end
					pdds_pkg::CMD_DOWN_WRAP: begin
						if (dim_level <= pdds_pkg::MIN_BRIGHTNESS)
							dim_level = clamp_request(pdds_pkg::MAX_BRIGHTNESS);
						else
							dim_level--;
					end
					default: dim_level = 0;
				endcase
				push_beat(pdds_pkg::KIND_LEVEL, pdds_pkg::ALL_ZEROS, dim_level, 1'b1);
			end
		endcase
	endfunction

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_command(pdds_pkg::command_t c, logic [pdds_pkg::LEVEL_REQ_W-1:0] req,
			logic [pdds_pkg::WORD_W-1:0] w);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid         <= 1'b1;
		cmd_bus.command       <= c;
		cmd_bus.level_request <= req;
		cmd_bus.segment_word  <= w;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		predict_display(c, req, w);
	endtask

	function automatic logic [pdds_pkg::WORD_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [pdds_pkg::LEVEL_REQ_W-1:0] random_request();
		if ($urandom_range(0, 1))
			return pdds_pkg::LEVEL_REQ_W'($urandom_range(0, pdds_pkg::MAX_BRIGHTNESS + 2));
		return pdds_pkg::LEVEL_REQ_W'($urandom_range(0, 255));
	endfunction

	// sink side: random stall per beat, then compare with the oldest expectation
	initial begin
		display_beat_t want;
		int stall;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			@(posedge clk);
			while (!res_bus.valid) @(posedge clk);
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual kind %0d word %h level %0d",
					$time, res_bus.result_kind, res_bus.shift_word, res_bus.level_now);
				mismatch_count++;
			end else begin
				want = expected_beats.pop_front();
				if (res_bus.result_kind !== want.kind) begin
					$display("%0t: result_kind expected %0d actual %0d",
						$time, want.kind, res_bus.result_kind);
					mismatch_count++;
				end
				if (res_bus.shift_word !== want.word) begin
					$display("%0t: shift_word expected %h actual %h",
						$time, want.word, res_bus.shift_word);
					mismatch_count++;
				end
				if (res_bus.level_now !== want.lvl) begin
					$display("%0t: level_now expected %0d actual %0d",
						$time, want.lvl, res_bus.level_now);
					mismatch_count++;
				end
				if (res_bus.last !== want.last) begin
					$display("%0t: last expected %0d actual %0d",
						$time, want.last, res_bus.last);
					mismatch_count++;
				end
			end
		end
	end

	// a full pwm period from reset, with all-ones pattern loaded first
	task automatic test_reset_period();
		send_command(pdds_pkg::CMD_LOAD, 8'hFF, pdds_pkg::ALL_ONES);
		repeat (pdds_pkg::MAX_BRIGHTNESS)
			send_command(pdds_pkg::CMD_TICK, random_request(), random_word());
	endtask

	task automatic test_set_clamp();
		send_command(pdds_pkg::CMD_SET, 8'd0, pdds_pkg::ALL_ZEROS);
		send_command(pdds_pkg::CMD_SET, 8'd255, random_word());
		send_command(pdds_pkg::CMD_SET, pdds_pkg::LEVEL_REQ_W'(pdds_pkg::MAX_BRIGHTNESS + 1),
			pdds_pkg::ALL_ONES);
		send_command(pdds_pkg::CMD_SET, pdds_pkg::LEVEL_REQ_W'(pdds_pkg::MAX_BRIGHTNESS),
			random_word());
	endtask

	// saturation and wrap at both ends, and stepping from off
	task automatic test_step_limits();
		send_command(pdds_pkg::CMD_UP, 8'hFF, pdds_pkg::ALL_ZEROS);
		send_command(pdds_pkg::CMD_UP_WRAP, 8'h00, pdds_pkg::ALL_ONES);
		send_command(pdds_pkg::CMD_DOWN, random_request(), random_word());
		send_command(pdds_pkg::CMD_DOWN_WRAP, random_request(), random_word());
		send_command(pdds_pkg::CMD_OFF, random_request(), random_word());
		send_command(pdds_pkg::CMD_DOWN, random_request(), random_word());
		send_command(pdds_pkg::CMD_UP, random_request(), random_word());
		send_command(pdds_pkg::CMD_OFF, random_request(), random_word());
		send_command(pdds_pkg::CMD_UP_WRAP, random_request(), random_word());
		send_command(pdds_pkg::CMD_OFF, random_request(), random_word());
		send_command(pdds_pkg::CMD_DOWN_WRAP, random_request(), random_word());
	endtask

	task automatic test_random_traffic(int count, bit gaps);
		int k;
		pdds_pkg::command_t c;
		allow_gaps = gaps;
		repeat (count) begin
			k = $urandom_range(0, 99);
			if (k < 40)
				c = pdds_pkg::CMD_TICK;
			else if (k < 55)
				c = pdds_pkg::CMD_SET;
			else if (k < 62)
				c = pdds_pkg::CMD_UP;
			else if (k < 69)
				c = pdds_pkg::CMD_UP_WRAP;
			else if (k < 76)
				c = pdds_pkg::CMD_DOWN;
			else if (k < 83)
				c = pdds_pkg::CMD_DOWN_WRAP;
			else if (k < 90)
				c = pdds_pkg::CMD_OFF;
			else
				c = pdds_pkg::CMD_LOAD;
			send_command(c, random_request(), random_word());
		end
	endtask

	initial begin
		mismatch_count = 0;
		allow_gaps     = 1'b1;
		dim_level      = pdds_pkg::MAX_BRIGHTNESS;
		pwm_phase      = 0;
		seg_pattern    = pdds_pkg::ALL_ZEROS;
		arst_n                <= 1'b0;
		cmd_bus.valid         <= 1'b0;
		cmd_bus.command       <= pdds_pkg::CMD_TICK;
		cmd_bus.level_request <= '0;
		cmd_bus.segment_word  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_period();
		test_set_clamp();
		test_step_limits();
		test_random_traffic(200, 1'b1);
		test_random_traffic(200, 1'b0);
		test_random_traffic(200, 1'b1);
		test_random_traffic(200, 1'b1);
		cmd_bus.valid <= 1'b0;

		while (expected_beats.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### sim.f
sv/pdds_pkg.sv
sv/pdds_cmd_if.sv
sv/pdds_res_if.sv
sv/pwm_display_dimming_scheduler.sv
tb/tb_top.sv
